>>> hdl/cursor_line_edit_buffer_assert.svh
// Assertion macros for the line edit buffer RTL.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH
`define CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cle_pkg.sv
// Shared types and key codes for the cursor line edit buffer.
// No dependencies; used by the cell and the top level.
package cle_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] key_byte;
    logic [9:0] read_index;
  } edit_req_t;

  typedef struct packed {
    logic [7:0]  char_at;
    logic        index_valid;
    logic [10:0] text_length;
    logic [10:0] cursor_pos;
    logic        dropped;
  } edit_rsp_t;

  localparam logic KIND_EDIT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] KEY_HOME  = 8'h5B;  // '['
  localparam logic [7:0] KEY_END   = 8'h5D;  // ']'
  localparam logic [7:0] KEY_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] KEY_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] KEY_DEL   = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_INSERT,
    EDIT_DELETE
  } edit_op_t;

  typedef struct packed {
    edit_op_t   op;
    logic [7:0] key;
  } cell_cmd_t;

endpackage

>>> hdl/cursor_line_edit_buffer.sv
// Edit requests (cursor moves, inserts, deletes) complete when accepted; the result is registered.
// Inserts and deletes shift the cells from the edit point onward by one place.
// Read requests pass through the registered read tree, and their result is then registered.
// One request is in flight at a time; a new one is taken while the last result is being taken.
// Reset clears the length, the cursor and all control state; cell contents stay undefined.
`include "cursor_line_edit_buffer_assert.svh"

module cursor_line_edit_buffer #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cle_pkg::edit_req_t in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output cle_pkg::edit_rsp_t out_rsp
);
  import cle_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int AW     = $clog2(CAPACITY);
  localparam int LEAVES = 2**AW;
  localparam int IW     = (CW > 10) ? CW : 10;
  localparam int LCW    = $clog2(AW + 1);

  localparam logic [CW-1:0]  CAP_W     = CW'(CAPACITY);
  localparam logic [LCW-1:0] WAIT_LAST = LCW'(AW);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t         state;
  logic [LCW-1:0] wait_cnt;
  logic [CW-1:0]  count_q;
  logic [CW-1:0]  cursor_q;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  cursor_next;
  logic           drop;
  logic           in_fire;
  logic           out_free;
  logic           rsp_load;
  cell_cmd_t      cmd;
  logic [AW-1:0]  rd_addr;
  logic           rd_hit;
  logic [IW-1:0]  idx_ext;
  logic [7:0]     tree_data;
  logic [7:0]     cell_q [CAPACITY];
  logic [7:0]     leaves [LEAVES];

  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || (state != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign idx_ext  = IW'(in_req.read_index);

  // A result is loaded on an accepted edit, or when a read reaches the tree root and the output is free.
  assign rsp_load = (state == S_IDLE) ? (in_fire && in_req.kind == KIND_EDIT)
                                      : ((wait_cnt == WAIT_LAST) && out_free);

  always_comb begin
    cmd.op      = EDIT_NONE;
    cmd.key     = in_req.key_byte;
    count_next  = count_q;
    cursor_next = cursor_q;
    drop        = 1'b0;
    if (in_fire && in_req.kind == KIND_EDIT) begin
      unique case (in_req.key_byte)
        KEY_HOME: cursor_next = '0;
        KEY_END:  cursor_next = count_q;
        KEY_LEFT: begin
          if (cursor_q != '0) begin
            cursor_next = cursor_q - CW'(1);
          end
        end
        KEY_RIGHT: begin
          if (cursor_q < count_q) begin
            cursor_next = cursor_q + CW'(1);
          end
        end
        KEY_DEL: begin
          if (cursor_q != '0) begin
            cmd.op      = EDIT_DELETE;
            count_next  = count_q - CW'(1);
            cursor_next = cursor_q - CW'(1);
          end
        end
        default: begin
          if (count_q == CAP_W) begin
            drop = 1'b1;
          end else begin
            cmd.op      = EDIT_INSERT;
            count_next  = count_q + CW'(1);
            cursor_next = cursor_q + CW'(1);
          end
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] left;
    logic [7:0] right;
    if (i == 0) begin : g_first
      assign left = 8'h00;
    end else begin : g_mid_left
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_right
      assign right = cell_q[i+1];
    end
    cle_cell #(
      .INDEX(i),
      .CW   (CW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .cursor(cursor_q),
      .left  (left),
      .right (right),
      .data  (cell_q[i])
    );
  end

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_used
      assign leaves[j] = cell_q[j];
    end else begin : g_pad
      assign leaves[j] = 8'h00;
    end
  end

  cle_read_tree #(
    .AW(AW)
  ) u_read_tree (
    .clk   (clk),
    .leaves(leaves),
    .addr  (rd_addr),
    .data  (tree_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_cnt  <= '0;
      count_q   <= '0;
      cursor_q  <= '0;
      out_valid <= 1'b0;
    end else begin
      count_q  <= count_next;
      cursor_q <= cursor_next;
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_req.kind == KIND_READ) begin
              state    <= S_READ;
              wait_cnt <= '0;
              rd_addr  <= idx_ext[AW-1:0];
              rd_hit   <= idx_ext < IW'(count_q);
            end else begin
              out_rsp.char_at     <= 8'h00;
              out_rsp.index_valid <= 1'b0;
              out_rsp.text_length <= 11'(count_next);
              out_rsp.cursor_pos  <= 11'(cursor_next);
              out_rsp.dropped     <= drop;
            end
          end
        end
        S_READ: begin
          // The tree root holds the addressed character once the count reaches its end.
          if (wait_cnt != WAIT_LAST) begin
            wait_cnt <= wait_cnt + LCW'(1);
          end else if (out_free) begin
            state               <= S_IDLE;
            out_rsp.char_at     <= rd_hit ? tree_data : 8'h00;
            out_rsp.index_valid <= rd_hit;
            out_rsp.text_length <= 11'(count_q);
            out_rsp.cursor_pos  <= 11'(cursor_q);
            out_rsp.dropped     <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CLE_ASSERT_IMP(a_cursor_in_text, 1'b1, cursor_q <= count_q, "cursor beyond text end")
  `CLE_ASSERT_IMP(a_count_in_cap, 1'b1, count_q <= CAP_W, "text length beyond capacity")
  `CLE_ASSERT_NXT(a_read_holds_text, state == S_READ,
                  $stable(count_q) && $stable(cursor_q), "text changed during a read")
  `CLE_ASSERT_IMP(a_drop_only_full, out_valid && out_rsp.dropped,
                  count_q == CAP_W, "insert refused while buffer not full")

endmodule

>>> hdl/cle_cell.sv
// One character cell of the text chain.
// Depends on cle_pkg for the broadcast edit command.
module cle_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 11
) (
  input  logic              clk,
  input  cle_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]     cursor,
  input  logic [7:0]        left,
  input  logic [7:0]        right,
  output logic [7:0]        data
);
  import cle_pkg::*;

  localparam logic [CW-1:0] POS    = CW'(INDEX);
  localparam logic [CW-1:0] POS_UP = CW'(INDEX + 1);

  logic [7:0] data_next;

  // Cells past the cursor open a gap on insert; cells from the one before
  // the cursor onward close it on delete.
  always_comb begin
    data_next = data;
    unique case (cmd.op)
      EDIT_INSERT: begin
        if (POS > cursor) begin
          data_next = left;
        end else if (POS == cursor) begin
          data_next = cmd.key;
        end
      end
      EDIT_DELETE: begin
        if (POS_UP >= cursor) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> hdl/cle_read_tree.sv
// Registered binary selection tree that reads one character out of the cell chain.
// Standalone; each level of nodes is registered, from the bottom level up to the root.
module cle_read_tree #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic [7:0]    leaves [2**AW],
  input  logic [AW-1:0] addr,
  output logic [7:0]    data
);

  localparam int LEAVES = 2**AW;

  // Heap order: node 1 is the root, node n has children 2n and 2n+1.
  logic [7:0] node_q [1:LEAVES-1];

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    localparam int LVL = $clog2(n + 1) - 1;
    localparam int SEL = AW - 1 - LVL;
    if (2 * n >= LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        node_q[n] <= addr[SEL] ? leaves[2*n+1-LEAVES] : leaves[2*n-LEAVES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_q[n] <= addr[SEL] ? node_q[2*n+1] : node_q[2*n];
      end
    end
  end

  assign data = node_q[1];

endmodule
